[design/drls_pkg.sv]
// ---------------------------------------------------------------------------
// drls_pkg: shared types and helpers for the dense ReLU layer with SGD
// Request and response item layouts, codes, and the saturation functions.
// ---------------------------------------------------------------------------
package drls_pkg;

  // Request codes carried in req_type.
  typedef enum logic [2:0] {
    REQ_WRITE_WEIGHT = 3'd0,
    REQ_WRITE_BIAS   = 3'd1,
    REQ_INPUT        = 3'd2,
    REQ_READ_ACT     = 3'd3,
    REQ_GRADIENT     = 3'd4,
    REQ_READ_BACK    = 3'd5
  } req_code_t;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_STEP_RATE      = 2'd0,
    CFG_INPUTS_IN_USE  = 2'd1,
    CFG_OUTPUTS_IN_USE = 2'd2
  } cfg_code_t;

  // Sequencer states.
  typedef enum logic [3:0] {
    S_CLR,
    S_IDLE,
    S_F_RD,
    S_F_MUL,
    S_F_ACC,
    S_L_RD,
    S_L_WB,
    S_G_STEP,
    S_G_STEP2,
    S_G_RD,
    S_G_MUL1,
    S_G_W,
    S_G_MUL2,
    S_G_ACC,
    S_G_BIAS,
    S_R_RD
  } state_t;

  typedef struct packed {
    logic [2:0]         req_type;
    logic [9:0]         in_index;
    logic [7:0]         out_index;
    logic signed [31:0] sample_value;
    logic               last_element;
  } req_item_t;

  typedef struct packed {
    logic signed [31:0] read_value;
    logic [9:0]         read_index;
  } rsp_item_t;

  // Saturate a wide signed value to 32 bits.
  function automatic logic signed [31:0] sat32(input logic signed [64:0] v);
    logic signed [64:0] hi;
    logic signed [64:0] lo;
    hi = 65'sh0_7FFF_FFFF;
    lo = -65'sh0_8000_0000;
    if (v > hi) begin
      return 32'sh7FFF_FFFF;
    end else if (v < lo) begin
      return 32'sh8000_0000;
    end
    return v[31:0];
  endfunction

  // Saturate a wide signed value to 48 bits.
  function automatic logic signed [47:0] sat48(input logic signed [64:0] v);
    logic signed [64:0] hi;
    logic signed [64:0] lo;
    hi = 65'sh0_7FFF_FFFF_FFFF;
    lo = -65'sh0_8000_0000_0000;
    if (v > hi) begin
      return 48'sh7FFF_FFFF_FFFF;
    end else if (v < lo) begin
      return 48'sh8000_0000_0000;
    end
    return v[47:0];
  endfunction

endpackage

[design/drls_ram.sv]
// ---------------------------------------------------------------------------
// drls_ram: generic single-write, single-read memory
// One write port and one read port; the read data is registered.
// ---------------------------------------------------------------------------
module drls_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[design/drls_mac.sv]
// ---------------------------------------------------------------------------
// drls_mac: shared fixed-point multiplier
// Registered product of two signed operands, shifted right by the fraction
// width with rounding toward minus infinity.
// ---------------------------------------------------------------------------
module drls_mac #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic signed [32:0] a,
  input  logic signed [32:0] b,
  output logic signed [63:0] prod
);

  logic signed [65:0] full;

  // An arithmetic shift floors the scaled product.
  assign full = a * b;

  always_ff @(posedge clk) begin
    prod <= 64'(full >>> FRAC_BITS);
  end

endmodule

[design/dense_relu_layer_sgd.sv]
// ---------------------------------------------------------------------------
// dense_relu_layer_sgd: fully connected layer with ReLU and SGD training
// Weights, biases and activations in signed fixed point; one shared
// multiplier is stepped through the weight rows and columns by a sequencer.
// ---------------------------------------------------------------------------
// Usage:
//   Requests arrive on req (valid/ready); reads return one item on rsp
//   (valid/ready). Configuration is written on cfg_we/cfg_index/cfg_data.
//   req_ready is high only while the sequencer is idle.
// Steps per request:
//   weight or bias write: written as the request is taken while idle.
//   input element: for each output in use a read, a multiply, then a
//   saturating add into the sum memory; the last element then adds a read
//   and a write-back per entry of the larger of MAX_INPUTS and MAX_OUTPUTS
//   to form activations and clear sums and back-gradients.
//   gradient: the step is formed, then each input in use takes two
//   multiplies per weight on the one shared multiplier; the bias is last.
//   reads: the result is read, then waits in the output register.
// Reset: a clearing pass zeroes the sum, activation and back-gradient
//   memories; no request is taken then.
// Stall: a held result blocks only the next read from finishing; other
//   requests proceed while the result waits for its transfer.
// ---------------------------------------------------------------------------
module dense_relu_layer_sgd
  import drls_pkg::*;
#(
  parameter int MAX_INPUTS  = 1024,
  parameter int MAX_OUTPUTS = 256,
  parameter int FRAC_BITS   = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_ready,
  input  req_item_t   req,
  output logic        rsp_valid,
  input  logic        rsp_ready,
  output rsp_item_t   rsp,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int IAW  = $clog2(MAX_INPUTS);
  localparam int OAW  = $clog2(MAX_OUTPUTS);
  localparam int NIW  = $clog2(MAX_INPUTS + 1);
  localparam int NOW  = $clog2(MAX_OUTPUTS + 1);
  localparam int NCLR = (MAX_INPUTS > MAX_OUTPUTS) ? MAX_INPUTS : MAX_OUTPUTS;
  localparam int CW   = $clog2(NCLR + 1);
  localparam int WDEP = 2 ** (IAW + OAW);

  // Configuration registers.
  logic [15:0] rate_scale;
  logic [10:0] inputs_in_use;
  logic [8:0]  outputs_in_use;

  always_ff @(posedge clk) begin
    if (rst) begin
      rate_scale     <= 16'd33;
      inputs_in_use  <= 11'd784;
      outputs_in_use <= 9'd256;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_STEP_RATE:      rate_scale     <= cfg_data;
        CFG_INPUTS_IN_USE:  inputs_in_use  <= cfg_data[10:0];
        CFG_OUTPUTS_IN_USE: outputs_in_use <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  // Counts in use, bounded by the memory sizes.
  logic [NIW-1:0] ni;
  logic [NOW-1:0] no;

  assign ni = (32'(inputs_in_use) > MAX_INPUTS) ? NIW'(MAX_INPUTS) : NIW'(inputs_in_use);
  assign no = (32'(outputs_in_use) > MAX_OUTPUTS) ? NOW'(MAX_OUTPUTS) : NOW'(outputs_in_use);

  // Sequencer and latched request.
  state_t             state, state_next;
  logic [CW-1:0]      cnt, cnt_next;
  logic [2:0]         req_q;
  logic [9:0]         ii_q;
  logic [7:0]         oi_q;
  logic signed [31:0] val_q;
  logic               last_q;
  logic signed [31:0] step;
  logic signed [31:0] wnew;
  logic               accept;

  assign req_ready = (state == S_IDLE);
  assign accept    = req_valid && req_ready;

  // Index helpers.
  logic [31:0] ii_in32, oi_in32, ii_q32, oi_q32, cnt32;

  assign ii_in32 = 32'(req.in_index);
  assign oi_in32 = 32'(req.out_index);
  assign ii_q32  = 32'(ii_q);
  assign oi_q32  = 32'(oi_q);
  assign cnt32   = 32'(cnt);

  // Memory ports.
  logic                 w_we, b_we, x_we, s_we, a_we, g_we;
  logic [IAW+OAW-1:0]   w_waddr, w_raddr;
  logic [OAW-1:0]       b_waddr, b_raddr, s_waddr, s_raddr, a_waddr, a_raddr;
  logic [IAW-1:0]       x_waddr, x_raddr, g_waddr, g_raddr;
  logic [31:0]          w_wdata, b_wdata, x_wdata, a_wdata;
  logic [47:0]          s_wdata, g_wdata;
  logic [31:0]          w_rdata, b_rdata, x_rdata, a_rdata;
  logic [47:0]          s_rdata, g_rdata;

  drls_ram #(.WIDTH(32), .DEPTH(WDEP)) u_weight (
    .clk(clk), .we(w_we), .waddr(w_waddr), .wdata(w_wdata),
    .raddr(w_raddr), .rdata(w_rdata)
  );
  drls_ram #(.WIDTH(32), .DEPTH(MAX_OUTPUTS)) u_bias (
    .clk(clk), .we(b_we), .waddr(b_waddr), .wdata(b_wdata),
    .raddr(b_raddr), .rdata(b_rdata)
  );
  drls_ram #(.WIDTH(32), .DEPTH(MAX_INPUTS)) u_input (
    .clk(clk), .we(x_we), .waddr(x_waddr), .wdata(x_wdata),
    .raddr(x_raddr), .rdata(x_rdata)
  );
  drls_ram #(.WIDTH(48), .DEPTH(MAX_OUTPUTS)) u_sum (
    .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
    .raddr(s_raddr), .rdata(s_rdata)
  );
  drls_ram #(.WIDTH(32), .DEPTH(MAX_OUTPUTS)) u_act (
    .clk(clk), .we(a_we), .waddr(a_waddr), .wdata(a_wdata),
    .raddr(a_raddr), .rdata(a_rdata)
  );
  drls_ram #(.WIDTH(48), .DEPTH(MAX_INPUTS)) u_back (
    .clk(clk), .we(g_we), .waddr(g_waddr), .wdata(g_wdata),
    .raddr(g_raddr), .rdata(g_rdata)
  );

  // Read addresses follow the counter and the latched indexes, so read
  // data stays put while the counter holds. The activation and back-gradient
  // reads take the incoming indexes while idle, so a read request finds its
  // data ready in the cycle after its transfer.
  assign w_raddr = (req_q == REQ_GRADIENT) ? {cnt[IAW-1:0], oi_q32[OAW-1:0]}
                                           : {ii_q32[IAW-1:0], cnt[OAW-1:0]};
  assign b_raddr = (req_q == REQ_GRADIENT) ? oi_q32[OAW-1:0] : cnt[OAW-1:0];
  assign s_raddr = cnt[OAW-1:0];
  assign a_raddr = (state == S_IDLE) ? oi_in32[OAW-1:0] : oi_q32[OAW-1:0];
  assign x_raddr = cnt[IAW-1:0];
  assign g_raddr = (state == S_IDLE)        ? ii_in32[IAW-1:0] :
                   (req_q == REQ_GRADIENT) ? cnt[IAW-1:0] : ii_q32[IAW-1:0];

  // Shared multiplier.
  logic signed [32:0] mul_a, mul_b;
  logic signed [63:0] prod;

  drls_mac #(.FRAC_BITS(FRAC_BITS)) u_mac (
    .clk(clk), .a(mul_a), .b(mul_b), .prod(prod)
  );

  always_comb begin
    mul_a = 33'($signed(w_rdata));
    mul_b = 33'(val_q);
    case (state)
      S_G_STEP: begin
        mul_a = $signed({17'd0, rate_scale});
        mul_b = 33'(val_q);
      end
      S_G_MUL1: begin
        mul_a = 33'(step);
        mul_b = 33'($signed(x_rdata));
      end
      S_G_MUL2: begin
        mul_a = 33'(val_q);
        mul_b = 33'(wnew);
      end
      default: ;
    endcase
  end

  // Arithmetic around the multiplier.
  logic signed [64:0] sum_acc, act_sum, w_diff, back_acc, bias_diff;
  logic signed [31:0] step_sat, upd_sat, w_sat;

  assign sum_acc   = 65'($signed(s_rdata)) + 65'(prod);
  assign act_sum   = 65'($signed(s_rdata)) + 65'($signed(b_rdata));
  assign step_sat  = sat32(65'(prod));
  assign upd_sat   = sat32(65'(prod));
  assign w_diff    = 65'($signed(w_rdata)) - 65'(upd_sat);
  assign w_sat     = sat32(w_diff);
  assign back_acc  = 65'($signed(g_rdata)) + 65'(prod);
  assign bias_diff = 65'($signed(b_rdata)) - 65'(step);

  // Next state and memory write controls.
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    w_we = 1'b0; w_waddr = {ii_in32[IAW-1:0], oi_in32[OAW-1:0]}; w_wdata = req.sample_value;
    b_we = 1'b0; b_waddr = oi_in32[OAW-1:0]; b_wdata = req.sample_value;
    x_we = 1'b0; x_waddr = ii_in32[IAW-1:0]; x_wdata = req.sample_value;
    s_we = 1'b0; s_waddr = cnt[OAW-1:0]; s_wdata = '0;
    a_we = 1'b0; a_waddr = cnt[OAW-1:0]; a_wdata = '0;
    g_we = 1'b0; g_waddr = cnt[IAW-1:0]; g_wdata = '0;
    case (state)
      S_CLR: begin
        s_we = (cnt32 < MAX_OUTPUTS);
        a_we = (cnt32 < MAX_OUTPUTS);
        g_we = (cnt32 < MAX_INPUTS);
        if (cnt32 == NCLR - 1) begin
          state_next = S_IDLE;
          cnt_next   = '0;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_IDLE: begin
        cnt_next = '0;
        if (accept) begin
          case (req.req_type)
            REQ_WRITE_WEIGHT: begin
              w_we = (ii_in32 < MAX_INPUTS) && (oi_in32 < MAX_OUTPUTS);
            end
            REQ_WRITE_BIAS: begin
              b_we = (oi_in32 < MAX_OUTPUTS);
            end
            REQ_INPUT: begin
              if (ii_in32 < 32'(ni)) begin
                x_we = 1'b1;
                if (no != '0) begin
                  state_next = S_F_RD;
                end else if (req.last_element) begin
                  state_next = S_L_RD;
                end
              end else if (req.last_element) begin
                state_next = S_L_RD;
              end
            end
            REQ_GRADIENT: begin
              if (oi_in32 < 32'(no)) begin
                state_next = S_G_STEP;
              end
            end
            REQ_READ_ACT, REQ_READ_BACK: begin
              state_next = S_R_RD;
            end
            default: ;
          endcase
        end
      end
      S_F_RD:  state_next = S_F_MUL;
      S_F_MUL: state_next = S_F_ACC;
      S_F_ACC: begin
        s_we    = 1'b1;
        s_wdata = sat48(sum_acc);
        if (cnt32 + 1 < 32'(no)) begin
          cnt_next   = cnt + 1'b1;
          state_next = S_F_RD;
        end else if (last_q) begin
          cnt_next   = '0;
          state_next = S_L_RD;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_L_RD: state_next = S_L_WB;
      S_L_WB: begin
        // Activation from sum plus bias, clamped to [0, max].
        a_we = (cnt32 < 32'(no));
        if (act_sum < 0) begin
          a_wdata = '0;
        end else begin
          a_wdata = sat32(act_sum);
        end
        s_we = (cnt32 < MAX_OUTPUTS);
        g_we = (cnt32 < MAX_INPUTS);
        if (cnt32 == NCLR - 1) begin
          state_next = S_IDLE;
        end else begin
          cnt_next   = cnt + 1'b1;
          state_next = S_L_RD;
        end
      end
      S_G_STEP: state_next = S_G_STEP2;
      S_G_STEP2: begin
        cnt_next   = '0;
        state_next = (ni == '0) ? S_G_BIAS : S_G_RD;
      end
      S_G_RD:   state_next = S_G_MUL1;
      S_G_MUL1: state_next = S_G_W;
      S_G_W: begin
        w_we       = 1'b1;
        w_waddr    = {cnt[IAW-1:0], oi_q32[OAW-1:0]};
        w_wdata    = w_sat;
        state_next = S_G_MUL2;
      end
      S_G_MUL2: state_next = S_G_ACC;
      S_G_ACC: begin
        g_we    = ($signed(x_rdata) > 0);
        g_wdata = sat48(back_acc);
        if (cnt32 + 1 < 32'(ni)) begin
          cnt_next   = cnt + 1'b1;
          state_next = S_G_RD;
        end else begin
          state_next = S_G_BIAS;
        end
      end
      S_G_BIAS: begin
        b_we       = 1'b1;
        b_waddr    = oi_q32[OAW-1:0];
        b_wdata    = sat32(bias_diff);
        state_next = S_IDLE;
      end
      S_R_RD: begin
        if (!rsp_valid || rsp_ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  // Latched request and working values.
  always_ff @(posedge clk) begin
    if (accept) begin
      req_q  <= req.req_type;
      ii_q   <= req.in_index;
      oi_q   <= req.out_index;
      val_q  <= req.sample_value;
      last_q <= req.last_element;
    end
    if (state == S_G_STEP2) begin
      step <= step_sat;
    end
    if (state == S_G_W) begin
      wnew <= w_sat;
    end
  end

  // Output register: loaded when a read finishes, held until its transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (state == S_R_RD && (!rsp_valid || rsp_ready)) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_R_RD && (!rsp_valid || rsp_ready)) begin
      if (req_q == REQ_READ_ACT) begin
        rsp.read_value <= (oi_q32 < 32'(no)) ? $signed(a_rdata) : 32'sd0;
        rsp.read_index <= 10'(oi_q);
      end else begin
        rsp.read_value <= (ii_q32 < 32'(ni)) ? sat32(65'($signed(g_rdata))) : 32'sd0;
        rsp.read_index <= ii_q;
      end
    end
  end

endmodule
